/* design/qlsf_pkg.sv */
package qlsf_pkg;

	// field and datapath widths
	localparam int COORD_W = 14;
	localparam int STEP_W = 13;
	localparam int IDX_W = 2;
	localparam int WIDE_W = 128;
	localparam int ELEM_W = 64;
	localparam int PROD_W = 56;
	localparam int OPND_W = 28;

	// iteration counts of the shared wide unit
	localparam int MAC_STEPS = 64;
	localparam int DIV_STEPS = 128;
	localparam int UCNT_W = $clog2(DIV_STEPS);
	localparam int DET_STEPS = 9;

	localparam int DEF_MAX_POINTS = 256;
	localparam int DEF_MAX_SAMPLES = 64;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FIT_START = 2'd0;
	localparam logic [IDX_W-1:0] REG_FIT_STOP = 2'd1;
	localparam logic [IDX_W-1:0] REG_FIT_STEP = 2'd2;

	localparam logic [COORD_W-1:0] RST_FIT_START = 14'd768;
	localparam logic [COORD_W-1:0] RST_FIT_STOP = 14'd3072;
	localparam logic [STEP_W-1:0] RST_FIT_STEP = 13'd128;

	// saturation limits of fitted_y
	localparam logic [COORD_W-1:0] Y_POS_MAX = 14'h1FFF;
	localparam logic [COORD_W-1:0] Y_NEG_MAX = 14'h2000;

	typedef enum logic {
		OP_MAC,
		OP_DIV
	} unit_op_t;

	// one request to the wide unit: res = c +/- a*b, or quotient a / c
	typedef struct packed {
		unit_op_t op;
		logic sub;
		logic [WIDE_W-1:0] a;
		logic [ELEM_W-1:0] b;
		logic [WIDE_W-1:0] c;
	} unit_req_t;

	typedef struct packed {
		logic [31:0] sx;
		logic [39:0] sx2;
		logic [47:0] sx3;
		logic [63:0] sx4;
		logic [31:0] sy;
		logic [39:0] sxy;
		logic [47:0] sx2y;
	} sums_t;

	// normal matrix elements widened to 64 bits
	typedef struct packed {
		logic [ELEM_W-1:0] pw0;
		logic [ELEM_W-1:0] pw1;
		logic [ELEM_W-1:0] pw2;
		logic [ELEM_W-1:0] pw3;
		logic [ELEM_W-1:0] pw4;
		logic [ELEM_W-1:0] rh0;
		logic [ELEM_W-1:0] rh1;
		logic [ELEM_W-1:0] rh2;
	} elem_set_t;

	typedef enum logic [1:0] {
		C_ZERO,
		C_T,
		C_R
	} csel_t;

	typedef struct packed {
		logic a_t;
		logic [3:0] a_idx;
		logic [3:0] b_idx;
		csel_t c_sel;
		logic sub;
	} uop_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ACC  = 7'b0000010,
		S_DET  = 7'b0000100,
		S_NEG  = 7'b0001000,
		S_DBL  = 7'b0010000,
		S_SMP  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	// 3x3 determinant by cofactors along the top row, nine multiply-accumulates
	function automatic uop_t det_uop(input logic [3:0] s);
		uop_t u;
		u = '{a_t: 1'b0, a_idx: 4'd0, b_idx: 4'd0, c_sel: C_ZERO, sub: 1'b0};
		case (s)
			4'd0: u = '{1'b0, 4'd4, 4'd8, C_ZERO, 1'b0};
			4'd1: u = '{1'b0, 4'd5, 4'd7, C_T, 1'b1};
			4'd2: u = '{1'b1, 4'd0, 4'd0, C_ZERO, 1'b0};
			4'd3: u = '{1'b0, 4'd3, 4'd8, C_ZERO, 1'b0};
			4'd4: u = '{1'b0, 4'd5, 4'd6, C_T, 1'b1};
			4'd5: u = '{1'b1, 4'd0, 4'd1, C_R, 1'b1};
			4'd6: u = '{1'b0, 4'd3, 4'd7, C_ZERO, 1'b0};
			4'd7: u = '{1'b0, 4'd4, 4'd6, C_T, 1'b1};
			4'd8: u = '{1'b1, 4'd0, 4'd2, C_R, 1'b0};
			default: u = '{1'b0, 4'd0, 4'd0, C_ZERO, 1'b0};
		endcase
		return u;
	endfunction

endpackage

/* design/qlsf_wide_unit.sv */
module qlsf_wide_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	input qlsf_pkg::unit_req_t req,
	output logic done,
	output logic [qlsf_pkg::WIDE_W-1:0] res
);
	import qlsf_pkg::*;

	logic busy_q;
	logic done_q;
	unit_op_t op_q;
	logic sub_q;
	logic [UCNT_W-1:0] cnt_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] sh_q;
	logic [ELEM_W-1:0] mb_q;
	logic [WIDE_W-1:0] dv_q;
	logic [WIDE_W-1:0] rem_q;

	logic addend_neg;
	logic [WIDE_W-1:0] mac_sum;
	logic [WIDE_W-1:0] r_sh;
	logic [WIDE_W:0] diff;
	logic ge;
	logic last_iter;

	// multiply step: the top multiplier bit carries negative weight
	assign addend_neg = sub_q ^ (cnt_q == UCNT_W'(MAC_STEPS - 1));
	assign mac_sum = addend_neg ? acc_q - sh_q : acc_q + sh_q;

	// restoring divide step
	assign r_sh = {rem_q[WIDE_W-2:0], sh_q[WIDE_W-1]};
	assign diff = {1'b0, r_sh} - {1'b0, dv_q};
	assign ge = !diff[WIDE_W];

	assign last_iter = (op_q == OP_MAC) ? (cnt_q == UCNT_W'(MAC_STEPS - 1))
		: (cnt_q == UCNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= OP_MAC;
			sub_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
			sh_q <= '0;
			mb_q <= '0;
			dv_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// load operands
				busy_q <= 1'b1;
				op_q <= req.op;
				sub_q <= req.sub;
				cnt_q <= '0;
				sh_q <= req.a;
				mb_q <= req.b;
				dv_q <= req.c;
				rem_q <= '0;
				acc_q <= (req.op == OP_MAC) ? req.c : '0;
			end else if (busy_q) begin
				// advance one bit
				cnt_q <= cnt_q + 1'b1;
				sh_q <= sh_q << 1;
				if (op_q == OP_MAC) begin
					mb_q <= mb_q >> 1;
					if (mb_q[0])
						acc_q <= mac_sum;
				end else begin
					rem_q <= ge ? diff[WIDE_W-1:0] : r_sh;
					acc_q <= {acc_q[WIDE_W-2:0], ge};
				end
				if (last_iter) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res = acc_q;

endmodule

/* design/qlsf_accum.sv */
module qlsf_accum #(
	parameter int MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic clear,
	input logic [qlsf_pkg::COORD_W-1:0] x,
	input logic [qlsf_pkg::COORD_W-1:0] y,
	output logic done,
	output logic [$clog2(MAX_POINTS+1)-1:0] count,
	output qlsf_pkg::sums_t sums
);
	import qlsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [2:0] ST_LAST = 3'd5;

	logic run_q;
	logic [2:0] step_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic signed [OPND_W-1:0] x2_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [CNT_W-1:0] count_q;
	sums_t sums_q;

	logic signed [OPND_W-1:0] xs;
	logic signed [OPND_W-1:0] ys;
	logic signed [OPND_W-1:0] mul_a;
	logic signed [OPND_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	assign xs = {{(OPND_W-COORD_W){x_q[COORD_W-1]}}, x_q};
	assign ys = {{(OPND_W-COORD_W){y_q[COORD_W-1]}}, y_q};

	// pick the power product of this step
	always_comb begin
		case (step_q)
			3'd0: begin mul_a = xs; mul_b = xs; end
			3'd1: begin mul_a = prod_s1[OPND_W-1:0]; mul_b = xs; end
			3'd2: begin mul_a = x2_q; mul_b = x2_q; end
			3'd3: begin mul_a = xs; mul_b = ys; end
			3'd4: begin mul_a = x2_q; mul_b = ys; end
			default: begin mul_a = xs; mul_b = xs; end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			step_q <= '0;
			x_q <= '0;
			y_q <= '0;
			x2_q <= '0;
			prod_s1 <= '0;
			count_q <= '0;
			sums_q <= '0;
		end else if (clear) begin
			count_q <= '0;
			sums_q <= '0;
		end else if (start) begin
			x_q <= x;
			y_q <= y;
			run_q <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			// multiply this step, add the previous product
			prod_s1 <= mul_p;
			step_q <= step_q + 1'b1;
			case (step_q)
				3'd0: begin
					count_q <= count_q + 1'b1;
					sums_q.sx <= sums_q.sx + {{(32-COORD_W){x_q[COORD_W-1]}}, x_q};
					sums_q.sy <= sums_q.sy + {{(32-COORD_W){y_q[COORD_W-1]}}, y_q};
				end
				3'd1: begin
					x2_q <= prod_s1[OPND_W-1:0];
					sums_q.sx2 <= sums_q.sx2 + prod_s1[39:0];
				end
				3'd2: sums_q.sx3 <= sums_q.sx3 + prod_s1[47:0];
				3'd3: sums_q.sx4 <= sums_q.sx4 + {{(64-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
				3'd4: sums_q.sxy <= sums_q.sxy + prod_s1[39:0];
				default: begin
					sums_q.sx2y <= sums_q.sx2y + prod_s1[47:0];
					run_q <= 1'b0;
				end
			endcase
		end
	end

	assign done = run_q && (step_q == ST_LAST);
	assign count = count_q;
	assign sums = sums_q;

endmodule

/* design/quadratic_least_squares_fit.sv */
// An ordinary point is accepted and then takes six accumulate steps.
// A final point adds the solve: 41 multiply-accumulates on the shared 128-bit unit
// (64 shift-add steps each), and then per sample four multiply-accumulates and
// one 128-step divide.
// Throughput: one item at a time; ready is low until the item's last word is taken.
// Reset: arst_n clears the sums, count and flags and loads the default range.
module quadratic_least_squares_fit #(
	parameter int MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
	parameter int MAX_SAMPLES = qlsf_pkg::DEF_MAX_SAMPLES
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [qlsf_pkg::COORD_W-1:0] point_x,
	input logic [qlsf_pkg::COORD_W-1:0] point_y,
	input logic last_point,
	output logic out_valid,
	input logic out_ready,
	output logic [qlsf_pkg::COORD_W-1:0] sample_x,
	output logic [qlsf_pkg::COORD_W-1:0] fitted_y,
	output logic last_sample,
	output logic singular,
	output logic point_overflow,
	output logic empty_range,
	output logic clipped,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [qlsf_pkg::IDX_W-1:0] cfg_index,
	input logic [qlsf_pkg::COORD_W-1:0] cfg_data
);
	import qlsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int K_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	localparam logic [2:0] PC_LIN = 3'd0;
	localparam logic [2:0] PC_QUAD = 3'd1;
	localparam logic [2:0] PC_ABS = 3'd2;
	localparam logic [2:0] PC_RND = 3'd3;
	localparam logic [2:0] PC_DIV = 3'd4;

	function automatic logic [ELEM_W-1:0] elem(input elem_set_t e, input logic [1:0] j,
		input logic [3:0] idx);
		logic [1:0] row;
		logic [1:0] col;
		logic [2:0] pw;
		logic [ELEM_W-1:0] v;
		case (idx)
			4'd0: begin row = 2'd0; col = 2'd0; end
			4'd1: begin row = 2'd0; col = 2'd1; end
			4'd2: begin row = 2'd0; col = 2'd2; end
			4'd3: begin row = 2'd1; col = 2'd0; end
			4'd4: begin row = 2'd1; col = 2'd1; end
			4'd5: begin row = 2'd1; col = 2'd2; end
			4'd6: begin row = 2'd2; col = 2'd0; end
			4'd7: begin row = 2'd2; col = 2'd1; end
			default: begin row = 2'd2; col = 2'd2; end
		endcase
		pw = {1'b0, row} + {1'b0, col};
		case (pw)
			3'd0: v = e.pw0;
			3'd1: v = e.pw1;
			3'd2: v = e.pw2;
			3'd3: v = e.pw3;
			default: v = e.pw4;
		endcase
		// Cramer: column j-1 takes the right-hand side
		if (j != 2'd0 && col == j - 2'd1) begin
			case (row)
				2'd0: v = e.rh0;
				2'd1: v = e.rh1;
				default: v = e.rh2;
			endcase
		end
		return v;
	endfunction

	state_t state_q;
	logic wait_q;
	logic [3:0] s_q;
	logic [1:0] j_q;
	logic [2:0] pc_q;
	logic [1:0] nidx_q;
	logic last_q;
	logic ovf_q;
	logic sing_q;
	logic dneg_q;
	logic nneg_q;
	logic [WIDE_W-1:0] t_q;
	logic [WIDE_W-1:0] r_q;
	logic [WIDE_W-1:0] d_q;
	logic [WIDE_W-1:0] da_q;
	logic [WIDE_W-1:0] db_q;
	logic [WIDE_W-1:0] dc_q;
	logic [WIDE_W-1:0] dd_q;
	logic [COORD_W-1:0] start_q;
	logic [COORD_W-1:0] stop_q;
	logic [STEP_W-1:0] step_q;
	logic [COORD_W-1:0] sx_q;
	logic [K_W-1:0] k_q;
	logic [COORD_W-1:0] outx_q;
	logic [COORD_W-1:0] outy_q;
	logic outlast_q;
	logic outempty_q;
	logic outclip_q;

	logic in_fire;
	logic take_pt;
	logic acc_done;
	logic acc_clear;
	logic [CNT_W-1:0] pt_count;
	sums_t sums;
	elem_set_t es;
	uop_t uop;
	logic [ELEM_W-1:0] ea;
	logic [ELEM_W-1:0] eb;
	logic [WIDE_W-1:0] det_sel;
	unit_req_t req;
	logic unit_go;
	logic unit_done;
	logic [WIDE_W-1:0] unit_res;
	logic signed [2*COORD_W-1:0] sq;
	logic signed [COORD_W:0] nx;
	logic smp_last;
	logic range_empty;
	logic pos_clip;
	logic neg_clip;
	logic [COORD_W-1:0] y_val;
	logic y_clip;

	assign in_fire = in_valid && in_ready;
	assign take_pt = in_fire && (pt_count < CNT_W'(MAX_POINTS));
	assign acc_clear = (state_q == S_OUT) && out_ready && outlast_q;

	qlsf_accum #(
		.MAX_POINTS(MAX_POINTS)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.start(take_pt),
		.clear(acc_clear),
		.x(point_x),
		.y(point_y),
		.done(acc_done),
		.count(pt_count),
		.sums(sums)
	);

	// widen the sums into matrix elements
	always_comb begin
		es.pw0 = {{(ELEM_W-CNT_W){1'b0}}, pt_count};
		es.pw1 = {{32{sums.sx[31]}}, sums.sx};
		es.pw2 = {{24{sums.sx2[39]}}, sums.sx2};
		es.pw3 = {{16{sums.sx3[47]}}, sums.sx3};
		es.pw4 = sums.sx4;
		es.rh0 = {{32{sums.sy[31]}}, sums.sy};
		es.rh1 = {{24{sums.sxy[39]}}, sums.sxy};
		es.rh2 = {{16{sums.sx2y[47]}}, sums.sx2y};
	end

	assign uop = det_uop(s_q);
	assign ea = elem(es, j_q, uop.a_idx);
	assign eb = elem(es, j_q, uop.b_idx);
	assign sq = $signed(sx_q) * $signed(sx_q);

	always_comb begin
		case (nidx_q)
			2'd0: det_sel = d_q;
			2'd1: det_sel = da_q;
			2'd2: det_sel = db_q;
			default: det_sel = dc_q;
		endcase
	end

	// operand selection for the wide unit
	always_comb begin
		req.op = OP_MAC;
		req.sub = 1'b0;
		req.a = '0;
		req.b = '0;
		req.c = '0;
		case (state_q)
			S_DET: begin
				req.a = uop.a_t ? t_q : {{(WIDE_W-ELEM_W){ea[ELEM_W-1]}}, ea};
				req.b = eb;
				req.sub = uop.sub;
				case (uop.c_sel)
					C_T: req.c = t_q;
					C_R: req.c = r_q;
					default: req.c = '0;
				endcase
			end
			S_NEG: begin
				req.a = det_sel;
				req.b = ELEM_W'(1);
				req.sub = dneg_q;
			end
			S_DBL: begin
				req.a = d_q;
				req.b = ELEM_W'(2);
			end
			S_SMP: begin
				case (pc_q)
					PC_LIN: begin
						req.a = db_q;
						req.b = {{(ELEM_W-COORD_W){sx_q[COORD_W-1]}}, sx_q};
						req.c = da_q;
					end
					PC_QUAD: begin
						req.a = dc_q;
						req.b = {{(ELEM_W-2*COORD_W){sq[2*COORD_W-1]}}, sq};
						req.c = t_q;
					end
					PC_ABS: begin
						req.a = t_q;
						req.b = ELEM_W'(1);
						req.sub = nneg_q;
					end
					PC_RND: begin
						req.a = t_q;
						req.b = ELEM_W'(2);
						req.c = d_q;
					end
					default: begin
						req.op = OP_DIV;
						req.a = t_q;
						req.c = dd_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign unit_go = !wait_q && ((state_q == S_DET) || (state_q == S_NEG)
		|| (state_q == S_DBL) || ((state_q == S_SMP) && !sing_q));

	qlsf_wide_unit u_wide (
		.clk(clk),
		.arst_n(arst_n),
		.start(unit_go),
		.req(req),
		.done(unit_done),
		.res(unit_res)
	);

	// sample position bookkeeping and result rounding
	assign nx = $signed({sx_q[COORD_W-1], sx_q}) + $signed({2'b00, step_q});
	assign smp_last = (k_q == K_W'(MAX_SAMPLES - 1))
		|| (nx >= $signed({stop_q[COORD_W-1], stop_q}));
	assign range_empty = !($signed(start_q) < $signed(stop_q));
	assign pos_clip = |unit_res[WIDE_W-1:COORD_W-1];
	assign neg_clip = (|unit_res[WIDE_W-1:COORD_W])
		|| (unit_res[COORD_W-1] && (|unit_res[COORD_W-2:0]));

	always_comb begin
		if (!nneg_q) begin
			y_clip = pos_clip;
			y_val = pos_clip ? Y_POS_MAX : unit_res[COORD_W-1:0];
		end else begin
			y_clip = neg_clip;
			y_val = neg_clip ? Y_NEG_MAX : COORD_W'(-unit_res[COORD_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
			s_q <= '0;
			j_q <= '0;
			pc_q <= PC_LIN;
			nidx_q <= '0;
			last_q <= 1'b0;
			ovf_q <= 1'b0;
			sing_q <= 1'b0;
			dneg_q <= 1'b0;
			nneg_q <= 1'b0;
			t_q <= '0;
			r_q <= '0;
			d_q <= '0;
			da_q <= '0;
			db_q <= '0;
			dc_q <= '0;
			dd_q <= '0;
			start_q <= RST_FIT_START;
			stop_q <= RST_FIT_STOP;
			step_q <= RST_FIT_STEP;
			sx_q <= '0;
			k_q <= '0;
			outx_q <= '0;
			outy_q <= '0;
			outlast_q <= 1'b0;
			outempty_q <= 1'b0;
			outclip_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIT_START: start_q <= cfg_data;
					REG_FIT_STOP: stop_q <= cfg_data;
					REG_FIT_STEP: step_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end

			if (unit_go)
				wait_q <= 1'b1;
			if (unit_done)
				wait_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q <= last_point;
						if (take_pt) begin
							state_q <= S_ACC;
						end else begin
							// drop the word beyond capacity
							ovf_q <= 1'b1;
							if (last_point) begin
								state_q <= S_DET;
								j_q <= '0;
								s_q <= '0;
							end
						end
					end
				end
				S_ACC: begin
					if (acc_done) begin
						if (last_q) begin
							state_q <= S_DET;
							j_q <= '0;
							s_q <= '0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DET: begin
					if (unit_done) begin
						if (uop.a_t)
							r_q <= unit_res;
						else
							t_q <= unit_res;
						if (s_q == 4'(DET_STEPS - 1)) begin
							s_q <= '0;
							j_q <= j_q + 1'b1;
							case (j_q)
								2'd0: begin
									d_q <= unit_res;
									sing_q <= (unit_res == '0);
									dneg_q <= unit_res[WIDE_W-1];
								end
								2'd1: da_q <= unit_res;
								2'd2: db_q <= unit_res;
								default: begin
									dc_q <= unit_res;
									state_q <= S_NEG;
									nidx_q <= '0;
								end
							endcase
						end else begin
							s_q <= s_q + 1'b1;
						end
					end
				end
				S_NEG: begin
					// make the determinant positive
					if (unit_done) begin
						case (nidx_q)
							2'd0: d_q <= unit_res;
							2'd1: da_q <= unit_res;
							2'd2: db_q <= unit_res;
							default: begin
								dc_q <= unit_res;
								state_q <= S_DBL;
							end
						endcase
						nidx_q <= nidx_q + 1'b1;
					end
				end
				S_DBL: begin
					if (unit_done) begin
						dd_q <= unit_res;
						if (range_empty) begin
							outx_q <= '0;
							outy_q <= '0;
							outlast_q <= 1'b1;
							outempty_q <= 1'b1;
							outclip_q <= 1'b0;
							state_q <= S_OUT;
						end else begin
							sx_q <= start_q;
							k_q <= '0;
							pc_q <= PC_LIN;
							state_q <= S_SMP;
						end
					end
				end
				S_SMP: begin
					if (sing_q) begin
						outx_q <= sx_q;
						outy_q <= '0;
						outlast_q <= smp_last;
						outempty_q <= 1'b0;
						outclip_q <= 1'b0;
						state_q <= S_OUT;
					end else if (unit_done) begin
						if (pc_q == PC_DIV) begin
							outx_q <= sx_q;
							outy_q <= y_val;
							outlast_q <= smp_last;
							outempty_q <= 1'b0;
							outclip_q <= y_clip;
							state_q <= S_OUT;
						end else begin
							t_q <= unit_res;
							if (pc_q == PC_QUAD)
								nneg_q <= unit_res[WIDE_W-1];
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (outlast_q) begin
							ovf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							// advance to the next sample position
							sx_q <= nx[COORD_W-1:0];
							k_q <= k_q + 1'b1;
							pc_q <= PC_LIN;
							state_q <= S_SMP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cfg_ready = 1'b1;
	assign sample_x = outx_q;
	assign fitted_y = outy_q;
	assign last_sample = outlast_q;
	assign singular = sing_q;
	assign point_overflow = ovf_q;
	assign empty_range = outempty_q;
	assign clipped = outclip_q;

endmodule

/* design/qlsf_checker.sv */
module qlsf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [qlsf_pkg::COORD_W-1:0] sample_x,
	input logic [qlsf_pkg::COORD_W-1:0] fitted_y,
	input logic last_sample,
	input logic singular,
	input logic empty_range,
	input logic clipped
);
	import qlsf_pkg::*;

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_x)
			&& $stable(fitted_y) && $stable(last_sample))
		else $error("result word changed while stalled");

	// one word at a time: no input taken while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// empty range gives a single zero word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_range |-> last_sample && (fitted_y == '0)
			&& (sample_x == '0) && !clipped)
		else $error("malformed empty range word");

	// saturation only at the rails, never on a singular fit
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> ((fitted_y == Y_POS_MAX) || (fitted_y == Y_NEG_MAX))
			&& !singular)
		else $error("clipped word off the rails");

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (.*);
